FILE: rtl/ppap_pkg.sv
// ----------------------------------------------------------------------------
// ppap_pkg
// Types and constants shared by the plain-text PPM pixel parser.
// ----------------------------------------------------------------------------
package ppap_pkg;

  typedef enum logic [2:0] {
    PH_P, PH_3, PH_SP, PH_W, PH_H, PH_MAX, PH_PIX, PH_WAIT
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_MAGIC    = 3'd1,
    ERR_CHAR     = 3'd2,
    ERR_MAXVAL   = 3'd3,
    ERR_SAMPLE   = 3'd4,
    ERR_DIM      = 3'd5,
    ERR_EARLY    = 3'd6
  } err_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_DIV, ST_OUT
  } seq_e;

  localparam logic [16:0] TokenCap = 17'd65536;
  localparam logic [7:0]  ChHash   = 8'h23;
  localparam logic [7:0]  ChP      = 8'h50;
  localparam logic [7:0]  Ch3      = 8'h33;
  localparam logic [7:0]  ChLf     = 8'h0a;
  localparam logic [7:0]  Ch0      = 8'h30;
  localparam logic [7:0]  Ch9      = 8'h39;
  localparam logic [7:0]  FullScale = 8'hff;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [7:0]  red_value;
    logic [7:0]  green_value;
    logic [7:0]  blue_value;
    logic        last_item;
    logic [2:0]  error_code;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [23:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

endpackage

FILE: rtl/ppap_divider.sv
// ----------------------------------------------------------------------------
// ppap_divider
// Restoring divider, two quotient bits per cycle, 8-bit quotient.
// ----------------------------------------------------------------------------
module ppap_divider
  import ppap_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  div_req_t   req_i,
  output logic       done_o,
  output logic [7:0] quot_o
);

  logic [23:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic [7:0]  quo_q, quo_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;

  always_comb begin
    logic [24:0] trial;
    logic [24:0] r;
    logic [2:0]  sh;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    trial  = '0;
    r      = '0;
    sh     = '0;
    if (req_i.start) begin
      rem_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      quo_d  = '0;
      cnt_d  = 3'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      r = {1'b0, rem_q};
      for (int k = 0; k < 2; k++) begin
        sh = {cnt_q[1:0], 1'(k)};
        trial = {2'b0, dvs_q, 7'd0} >> sh;
        if (r >= trial) begin
          r = r - trial;
          quo_d[3'd7 - sh] = 1'b1;
        end
      end
      rem_d = r[23:0];
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd3) begin
        busy_d = 1'b0;
      end
    end
    if (busy_q && !req_i.start && cnt_q == 3'd3) begin
      done_o = 1'b1;
    end
  end

  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

endmodule

FILE: rtl/ppm_ascii_pixel_parser_core.sv
// ----------------------------------------------------------------------------
// ppm_ascii_pixel_parser_core
// Byte-serial plain-text PPM parser with an iterative sample scaler.
// ----------------------------------------------------------------------------
// A byte that closes a sample token starts the scaling 255*value/maxval,
// which runs through a shared divider that produces two quotient bits a
// cycle; no byte is taken while it runs. One byte is taken at a time, and
// a result waits in the output register until it is taken.
module ppm_ascii_pixel_parser_core
  import ppap_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096,
  parameter int MAX_SAMPLE    = 65535
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  output out_t out_data_o,
  output logic out_valid_o,
  input  logic out_ready_i
);

  localparam logic [16:0] MaxDim = 17'(MAX_DIMENSION);
  localparam logic [16:0] MaxSmp = 17'(MAX_SAMPLE);

  phase_e      ph_q, ph_d;
  seq_e        st_q, st_d;
  logic        cmt_q, cmt_d, tok_q, tok_d, eoi_q, eoi_d;
  logic [16:0] val_q, val_d;
  logic [12:0] w_q, w_d, h_q, h_d, col_q, col_d, row_q, row_d;
  logic [15:0] max_q, max_d;
  logic [1:0]  ci_q, ci_d;
  logic [7:0]  rh_q, rh_d, gh_q, gh_d;
  out_t        res_q, res_d;
  logic        ov_q, ov_d;
  div_req_t    dreq;
  logic        ddone;
  logic [7:0]  quot;

  ppap_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .done_o (ddone),
    .quot_o (quot)
  );

  assign in_ready_o  = (st_q == ST_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (dreq.start) st_d = ST_DIV;
      ST_DIV:  if (ddone) st_d = ST_OUT;
      ST_OUT:  st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [7:0]  c;
    logic        sp, dig, emit, fin, last, cl, rl;
    logic [20:0] t;
    out_t        r;
    c = in_data_i.data_byte;
    sp = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    dig = (c >= Ch0) && (c <= Ch9);
    ph_d = ph_q; cmt_d = cmt_q; tok_d = tok_q; val_d = val_q;
    w_d = w_q; h_d = h_q; max_d = max_q; ci_d = ci_q;
    rh_d = rh_q; gh_d = gh_q; col_d = col_q; row_d = row_q; eoi_d = eoi_q;
    res_d = res_q;
    ov_d = ov_q && !out_ready_i;
    dreq.start = 1'b0;
    dreq.dividend = {8'd0, val_q[15:0]} * 24'(FullScale);
    dreq.divisor = max_q;
    r = '0; emit = 1'b0; fin = 1'b0; last = 1'b0;
    t = '0; cl = 1'b0; rl = 1'b0;
    if (st_q == ST_IDLE && in_valid_i && in_ready_o) begin
      if (in_data_i.end_of_input) begin
        if (ph_q != PH_WAIT) begin
          fin = tok_q;
          eoi_d = 1'b1;
          if (!fin || ph_q == PH_W || ph_q == PH_H) begin
            r.result_kind = KIND_ERROR;
            r.error_code = ERR_EARLY;
            emit = 1'b1;
            if (fin && val_q > MaxDim) r.error_code = ERR_DIM;
            fin = 1'b0;
          end
        end
        if (!fin) begin
          ph_d = PH_P; cmt_d = 1'b0; tok_d = 1'b0; val_d = '0; ci_d = '0;
        end
      end else begin
        case (ph_q)
          PH_P: if (c == ChP) ph_d = PH_3; else begin
            r.result_kind = KIND_ERROR; r.error_code = ERR_MAGIC; emit = 1'b1;
          end
          PH_3: if (c == Ch3) ph_d = PH_SP; else begin
            r.result_kind = KIND_ERROR; r.error_code = ERR_MAGIC; emit = 1'b1;
          end
          PH_SP: if (sp) ph_d = PH_W; else begin
            r.result_kind = KIND_ERROR; r.error_code = ERR_MAGIC; emit = 1'b1;
          end
          PH_W, PH_H, PH_MAX, PH_PIX: begin
            if (cmt_q) begin
              if (c == ChLf) cmt_d = 1'b0;
            end else if (dig) begin
              tok_d = 1'b1;
              t = {4'd0, val_q} * 21'd10 + 21'(c - Ch0);
              val_d = (t > 21'(TokenCap)) ? TokenCap : t[16:0];
            end else if (sp || c == ChHash) begin
              if (c == ChHash) cmt_d = 1'b1;
              fin = tok_q;
              eoi_d = 1'b0;
            end else begin
              r.result_kind = KIND_ERROR; r.error_code = ERR_CHAR; emit = 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (fin) begin
        tok_d = 1'b0; val_d = '0;
        case (ph_q)
          PH_W, PH_H: begin
            if (val_q > MaxDim) begin
              r.result_kind = KIND_ERROR; r.error_code = ERR_DIM; emit = 1'b1;
            end else if (ph_q == PH_W) begin
              w_d = val_q[12:0]; ph_d = PH_H;
            end else begin
              h_d = val_q[12:0]; ph_d = PH_MAX;
            end
          end
          PH_MAX: begin
            if (val_q == '0 || val_q > MaxSmp) begin
              r.result_kind = KIND_ERROR; r.error_code = ERR_MAXVAL;
            end else begin
              max_d = val_q[15:0]; col_d = '0; row_d = '0; ci_d = '0;
              last = (w_q == '0) || (h_q == '0);
              r.result_kind = KIND_HEADER; r.image_width = w_q;
              r.image_height = h_q; r.last_item = last;
              ph_d = last ? PH_WAIT : PH_PIX;
              if (!last && in_data_i.end_of_input) begin
                r = '0; r.result_kind = KIND_ERROR; r.error_code = ERR_EARLY;
              end
            end
            emit = 1'b1;
          end
          PH_PIX: begin
            if ({1'b0, val_q} > {2'b0, max_q}) begin
              r.result_kind = KIND_ERROR; r.error_code = ERR_SAMPLE; emit = 1'b1;
            end else begin
              dreq.start = 1'b1;
            end
          end
          default: ;
        endcase
        if (in_data_i.end_of_input && !dreq.start) begin
          ph_d = PH_P; cmt_d = 1'b0; tok_d = 1'b0; val_d = '0; ci_d = '0;
          emit = 1'b1;
        end
      end
      if (emit && r.result_kind == KIND_ERROR && !in_data_i.end_of_input) begin
        ph_d = PH_WAIT; cmt_d = 1'b0; tok_d = 1'b0; val_d = '0;
      end
    end else if (st_q == ST_OUT) begin
      case (ci_q)
        2'd0: begin rh_d = quot; ci_d = 2'd1; end
        2'd1: begin gh_d = quot; ci_d = 2'd2; end
        default: begin
          ci_d = 2'd0;
          cl = (14'(col_q) + 14'd1) >= 14'(w_q);
          rl = (14'(row_q) + 14'd1) >= 14'(h_q);
          last = cl && rl;
          r.result_kind = KIND_PIXEL; r.red_value = rh_q;
          r.green_value = gh_q; r.blue_value = quot; r.last_item = last;
          emit = 1'b1;
          if (cl) begin col_d = '0; row_d = row_q + 13'd1; end
          else col_d = col_q + 13'd1;
          if (last) ph_d = PH_WAIT;
        end
      endcase
      if (eoi_q) begin
        if (!(emit && last)) begin
          r = '0; r.result_kind = KIND_ERROR; r.error_code = ERR_EARLY;
          emit = 1'b1;
        end
        ph_d = PH_P; cmt_d = 1'b0; tok_d = 1'b0; val_d = '0; ci_d = '0;
      end
    end
    if (emit) begin
      res_d = r; ov_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_P; st_q <= ST_IDLE; cmt_q <= 1'b0; tok_q <= 1'b0;
      val_q <= '0; ci_q <= '0; ov_q <= 1'b0; eoi_q <= 1'b0;
      w_q <= '0; h_q <= '0; max_q <= '0; col_q <= '0; row_q <= '0;
      rh_q <= '0; gh_q <= '0;
    end else begin
      ph_q <= ph_d; st_q <= st_d; cmt_q <= cmt_d; tok_q <= tok_d;
      val_q <= val_d; ci_q <= ci_d; ov_q <= ov_d; eoi_q <= eoi_d;
      w_q <= w_d; h_q <= h_d; max_q <= max_d; col_q <= col_d; row_q <= row_d;
      rh_q <= rh_d; gh_q <= gh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !in_ready_o) else $error("accepted while scaling");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE && st_d == ST_DIV) |=> (st_q == ST_DIV) [*4] ##1 (st_q == ST_OUT))
    else $error("divider latency");
  a_tok_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    val_q <= TokenCap) else $error("token above cap");

endmodule
